// File: design/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg
// Shared types, codes and field widths for the sorted key table.
// ----------------------------------------------------------------------------
package skt_pkg;

  // Default sizing of the table.
  localparam int CAPACITY_DEF  = 64;
  localparam int KEY_WIDTH_DEF = 32;

  // Fixed widths of the port fields.
  localparam int OP_W       = 2;
  localparam int KEY_W      = 32;
  localparam int INDEX_W    = 6;
  localparam int STATUS_W   = 2;
  localparam int VALUE_W    = 32;
  localparam int POSITION_W = 6;
  localparam int COUNT_W    = 7;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FIND   = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_RANGE   = 2'd2,
    STATUS_MISSING = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT_UP,
    ST_SHIFT_DN,
    ST_READ,
    ST_DONE
  } state_t;

  typedef struct packed {
    status_t                 status;
    logic [VALUE_W-1:0]      value;
    logic [POSITION_W-1:0]   position;
    logic [COUNT_W-1:0]      count;
  } result_t;

endpackage

// File: design/sorted_key_table_core.sv
// ----------------------------------------------------------------------------
// sorted_key_table_core
// Table of keys kept in ascending order in one RAM, with insert, remove,
// find and read operations and a selectable signed or unsigned ordering.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake            Payload
//  in       input      in_valid/in_ready    op, key, index
//  out      output     out_valid/out_ready  status, value, position, count
//  cfg      input      cfg_valid/cfg_ready  compare_signed
//
// Insert scans for its slot and then moves every later entry up a slot;
// find stops at the first hit and scans every entry on a miss; remove
// moves every entry above index down a slot; read does one RAM read; errors
// on full or bad index skip the RAM. The single RAM read port sets the pace:
// one entry is read and one moved per cycle.
// Reset is synchronous and clears the count, so no RAM clearing pass runs.
// A new transaction is taken while the previous result waits in the output
// register; a stalled output holds the sequencer only at its final step.
// ----------------------------------------------------------------------------
module sorted_key_table_core import skt_pkg::*; #(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [OP_W-1:0]       op,
  input  logic [KEY_W-1:0]      key,
  input  logic [INDEX_W-1:0]    index,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [STATUS_W-1:0]   status,
  output logic [VALUE_W-1:0]    value,
  output logic [POSITION_W-1:0] position,
  output logic [COUNT_W-1:0]    count,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  compare_signed
);

  localparam int IDX_W = $clog2(CAPACITY);

  logic                 cmp_signed;
  logic                 res_valid;
  logic                 res_ready;
  result_t              res;
  result_t              out_res;
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic [KEY_WIDTH-1:0] rd_data;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [KEY_WIDTH-1:0] wr_data;

  assign cfg_ready = 1'b1;
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_signed <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        cmp_signed <= compare_signed;
      end
      if (res_valid && res_ready) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign status   = out_res.status;
  assign value    = out_res.value;
  assign position = out_res.position;
  assign count    = out_res.count;

  skt_seq #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_seq (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .op             (op),
    .key            (key),
    .index          (index),
    .compare_signed (cmp_signed),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .res_out        (res),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data)
  );

  skt_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

// File: design/skt_ram.sv
// ----------------------------------------------------------------------------
// skt_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module skt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/skt_seq.sv
// ----------------------------------------------------------------------------
// skt_seq
// Operation sequencer: scans and shifts the table through the RAM ports,
// keeps the entry count and stages one result per transaction.
// ----------------------------------------------------------------------------
module skt_seq import skt_pkg::*; #(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [OP_W-1:0]             op,
  input  logic [KEY_W-1:0]            key,
  input  logic [INDEX_W-1:0]          index,
  input  logic                        compare_signed,
  output logic                        res_valid,
  input  logic                        res_ready,
  output result_t                     res_out,
  output logic                        rd_en,
  output logic [$clog2(CAPACITY)-1:0] rd_addr,
  input  logic [KEY_WIDTH-1:0]        rd_data,
  output logic                        wr_en,
  output logic [$clog2(CAPACITY)-1:0] wr_addr,
  output logic [KEY_WIDTH-1:0]        wr_data
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  state_t               state, state_next;
  op_t                  op_q, op_q_next;
  logic [KEY_WIDTH-1:0] key_q, key_q_next;
  logic [CNT_W-1:0]     entry_count, entry_count_next;
  logic [CNT_W-1:0]     rd_ptr, rd_ptr_next;
  logic [CNT_W-1:0]     at_ptr, at_ptr_next;
  logic                 pend, pend_next;
  logic [CNT_W-1:0]     pend_addr, pend_addr_next;
  result_t              res, res_next;

  logic [KEY_WIDTH-1:0] sign_flip;
  logic                 in_range;
  logic [CNT_W-1:0]     idx_n;
  logic                 hit;
  logic                 more;
  logic [CNT_W-1:0]     pend_inc, pend_dec, rd_dec;

  // Signed ordering is unsigned ordering with the sign bit inverted.
  assign sign_flip = compare_signed ? (KEY_WIDTH'(1) << (KEY_WIDTH - 1)) : '0;
  assign in_range  = CMP_W'(index) < CMP_W'(entry_count);
  assign idx_n     = CNT_W'(index);
  assign pend_inc  = pend_addr + CNT_W'(1);
  assign pend_dec  = pend_addr - CNT_W'(1);
  assign rd_dec    = rd_ptr - CNT_W'(1);

  always_comb begin
    if (op_q == OP_INSERT) begin
      hit = pend && ((key_q ^ sign_flip) <= (rd_data ^ sign_flip));
    end else begin
      hit = pend && (rd_data == key_q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      entry_count <= '0;
      pend        <= 1'b0;
    end else begin
      state       <= state_next;
      entry_count <= entry_count_next;
      pend        <= pend_next;
    end
    op_q      <= op_q_next;
    key_q     <= key_q_next;
    rd_ptr    <= rd_ptr_next;
    at_ptr    <= at_ptr_next;
    pend_addr <= pend_addr_next;
    res       <= res_next;
  end

  always_comb begin
    state_next       = state;
    op_q_next        = op_q;
    key_q_next       = key_q;
    entry_count_next = entry_count;
    rd_ptr_next      = rd_ptr;
    at_ptr_next      = at_ptr;
    pend_next        = pend;
    pend_addr_next   = pend_addr;
    res_next         = res;
    in_ready         = 1'b0;
    res_valid        = 1'b0;
    rd_en            = 1'b0;
    rd_addr          = '0;
    wr_en            = 1'b0;
    wr_addr          = '0;
    wr_data          = rd_data;
    more             = 1'b0;

    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_q_next    = op_t'(op);
          key_q_next   = KEY_WIDTH'(key);
          res_next     = '0;
          pend_next    = 1'b0;
          rd_ptr_next  = '0;
          case (op_t'(op))
            OP_INSERT: begin
              if (entry_count == CNT_W'(CAPACITY)) begin
                res_next.status = STATUS_FULL;
                state_next      = ST_DONE;
              end else begin
                state_next = ST_SCAN;
              end
            end
            OP_REMOVE: begin
              if (!in_range) begin
                res_next.status = STATUS_RANGE;
                state_next      = ST_DONE;
              end else begin
                rd_ptr_next = idx_n + CNT_W'(1);
                state_next  = ST_SHIFT_DN;
              end
            end
            OP_FIND: begin
              state_next = ST_SCAN;
            end
            OP_READ: begin
              if (!in_range) begin
                res_next.status = STATUS_RANGE;
                state_next      = ST_DONE;
              end else begin
                rd_en             = 1'b1;
                rd_addr           = idx_n[IDX_W-1:0];
                res_next.position = POSITION_W'(idx_n);
                state_next        = ST_READ;
              end
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end

      // One read issued per cycle; the compare looks at the previous read.
      ST_SCAN: begin
        more = rd_ptr < entry_count;
        if (hit) begin
          if (op_q == OP_INSERT) begin
            at_ptr_next = pend_addr;
            rd_ptr_next = entry_count;
            pend_next   = 1'b0;
            state_next  = ST_SHIFT_UP;
          end else begin
            res_next.status   = STATUS_OK;
            res_next.value    = VALUE_W'(rd_data);
            res_next.position = POSITION_W'(pend_addr);
            state_next        = ST_DONE;
          end
        end else if (!pend && !more) begin
          if (op_q == OP_INSERT) begin
            at_ptr_next = entry_count;
            rd_ptr_next = entry_count;
            state_next  = ST_SHIFT_UP;
          end else begin
            res_next.status = STATUS_MISSING;
            state_next      = ST_DONE;
          end
        end else begin
          pend_next      = more;
          pend_addr_next = rd_ptr;
          if (more) begin
            rd_en       = 1'b1;
            rd_addr     = rd_ptr[IDX_W-1:0];
            rd_ptr_next = rd_ptr + CNT_W'(1);
          end
        end
      end

      // Walk down from the top entry, moving each one up a slot.
      ST_SHIFT_UP: begin
        if (pend) begin
          wr_en   = 1'b1;
          wr_addr = pend_inc[IDX_W-1:0];
        end
        if (rd_ptr > at_ptr) begin
          rd_en          = 1'b1;
          rd_addr        = rd_dec[IDX_W-1:0];
          pend_next      = 1'b1;
          pend_addr_next = rd_dec;
          rd_ptr_next    = rd_dec;
        end else if (!pend) begin
          wr_en             = 1'b1;
          wr_addr           = at_ptr[IDX_W-1:0];
          wr_data           = key_q;
          entry_count_next  = entry_count + CNT_W'(1);
          res_next.status   = STATUS_OK;
          res_next.position = POSITION_W'(at_ptr);
          state_next        = ST_DONE;
        end else begin
          pend_next = 1'b0;
        end
      end

      // Walk up from the removed slot, moving each later entry down a slot.
      ST_SHIFT_DN: begin
        if (pend) begin
          wr_en   = 1'b1;
          wr_addr = pend_dec[IDX_W-1:0];
        end
        if (rd_ptr < entry_count) begin
          rd_en          = 1'b1;
          rd_addr        = rd_ptr[IDX_W-1:0];
          pend_next      = 1'b1;
          pend_addr_next = rd_ptr;
          rd_ptr_next    = rd_ptr + CNT_W'(1);
        end else if (!pend) begin
          entry_count_next = entry_count - CNT_W'(1);
          res_next.status  = STATUS_OK;
          state_next       = ST_DONE;
        end else begin
          pend_next = 1'b0;
        end
      end

      ST_READ: begin
        res_next.status = STATUS_OK;
        res_next.value  = VALUE_W'(rd_data);
        state_next      = ST_DONE;
      end

      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res_out       = res;
    res_out.count = COUNT_W'(entry_count);
  end

endmodule

// File: test/sorted_key_table_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table_core_test
// Self-checking bench for the sorted key table. A short table of directed
// transactions is followed by phases of random traffic, each phase under its
// own key ordering. Every result is compared field by field with its typed
// directed row, or else with a table model run alongside. Both sides stall at random.
// ----------------------------------------------------------------------------
module sorted_key_table_core_test;
  import skt_pkg::*;

  localparam int TABLE_DEPTH      = CAPACITY_DEF;
  localparam int GAP_MAX          = 18;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT      = 3000;
  localparam int DRAIN_CYCLES     = 150;
  localparam int NUM_PHASES       = 10;
  localparam int PHASE_ITEMS      = 125;
  localparam int HOLD_PHASE       = 4;

  typedef struct {
    op_t                 op;
    logic [KEY_W-1:0]    key;
    logic [INDEX_W-1:0]  index;
    bit                  typed;
    result_t             want;
  } stim_row_t;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic [OP_W-1:0]       op;
  logic [KEY_W-1:0]      key;
  logic [INDEX_W-1:0]    index;
  logic                  out_valid;
  logic                  out_ready;
  logic [STATUS_W-1:0]   status;
  logic [VALUE_W-1:0]    value;
  logic [POSITION_W-1:0] position;
  logic [COUNT_W-1:0]    count;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic                  compare_signed;

  // Shadow copy of the table and its ordering mode.
  logic [KEY_W-1:0] table_keys [TABLE_DEPTH];
  int               table_count;
  bit               order_signed;

  result_t   pending_results [$];
  stim_row_t directed_rows [$];
  int        mismatch_count;
  int        quiet_cycles;
  bit        send_no_idle;
  bit        recv_no_idle;
  bit        long_hold_req;

  sorted_key_table_core dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .op             (op),
    .key            (key),
    .index          (index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .value          (value),
    .position       (position),
    .count          (count),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .compare_signed (compare_signed)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Signed ordering flips the top bit so that an unsigned compare orders
  // keys as two's complement.
  function automatic logic [KEY_W-1:0] order_key(logic [KEY_W-1:0] k);
    return order_signed ? (k ^ {1'b1, {(KEY_W-1){1'b0}}}) : k;
  endfunction

  function automatic result_t apply_table_op(op_t o, logic [KEY_W-1:0] k,
                                             logic [INDEX_W-1:0] ix);
    result_t r;
    int      at;
    int      n;
    r.status   = STATUS_OK;
    r.value    = '0;
    r.position = '0;
    case (o)
      OP_INSERT: begin
        if (table_count >= TABLE_DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          at = table_count;
          for (n = 0; n < table_count && at == table_count; n++)
            if (order_key(k) <= order_key(table_keys[n])) at = n;
          for (n = table_count; n > at; n--) table_keys[n] = table_keys[n-1];
          table_keys[at] = k;
          table_count++;
          r.position = at[POSITION_W-1:0];
        end
      end
      OP_REMOVE: begin
        if (ix >= table_count) begin
          r.status = STATUS_RANGE;
        end else begin
          for (n = ix; n + 1 < table_count; n++) table_keys[n] = table_keys[n+1];
          table_count--;
        end
      end
      OP_FIND: begin
        r.status = STATUS_MISSING;
        for (n = 0; n < table_count && r.status == STATUS_MISSING; n++)
          if (table_keys[n] == k) begin
            r.status   = STATUS_OK;
            r.value    = table_keys[n];
            r.position = n[POSITION_W-1:0];
          end
      end
      default: begin
        if (ix >= table_count) begin
          r.status = STATUS_RANGE;
        end else begin
          r.value    = table_keys[ix];
          r.position = ix;
        end
      end
    endcase
    r.count = table_count[COUNT_W-1:0];
    return r;
  endfunction

  // Keys come from the full range, from a pool of corner values, or from the
  // table itself so that finds hit and equal keys pile up.
  function automatic logic [KEY_W-1:0] pick_key();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel >= 7 && table_count > 0) return table_keys[$urandom_range(0, table_count - 1)];
    if (sel >= 4) begin
      case ($urandom_range(0, 7))
        0:       return 32'h0000_0000;
        1:       return 32'h0000_0001;
        2:       return 32'h7FFF_FFFF;
        3:       return 32'h8000_0000;
        4:       return 32'h8000_0001;
        5:       return 32'hFFFF_FFFF;
        6:       return 32'h0000_1234;
        default: return 32'hFFFF_1234;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [INDEX_W-1:0] pick_index();
    if (table_count > 0 && $urandom_range(0, 9) < 8)
      return INDEX_W'($urandom_range(0, table_count - 1));
    return INDEX_W'($urandom_range(0, 63));
  endfunction

  function automatic void add_row(op_t o, logic [KEY_W-1:0] k, logic [INDEX_W-1:0] ix,
                                  bit typed, status_t s, logic [VALUE_W-1:0] v,
                                  logic [POSITION_W-1:0] p, logic [COUNT_W-1:0] c);
    stim_row_t row;
    row.op            = o;
    row.key           = k;
    row.index         = ix;
    row.typed         = typed;
    row.want.status   = s;
    row.want.value    = v;
    row.want.position = p;
    row.want.count    = c;
    directed_rows.push_back(row);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("MISMATCH %s: expected %0h, got %0h at %0t", what, want, got, $realtime);
    mismatch_count++;
  endtask

  // Offers one transaction and records its expected result once accepted.
  // in_valid stays high on return so a back-to-back item needs no toggle.
  task automatic send_item(op_t o, logic [KEY_W-1:0] k, logic [INDEX_W-1:0] ix,
                           bit typed, result_t typed_want);
    int      gap;
    result_t predicted;
    gap = send_no_idle ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= o;
    key      <= k;
    index    <= ix;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = apply_table_op(o, k, ix);
    pending_results.push_back(typed ? typed_want : predicted);
  endtask

  task automatic write_compare_mode(bit mode);
    cfg_valid      <= 1'b1;
    compare_signed <= mode;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    order_signed = mode;
    cfg_valid   <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  initial begin : result_monitor
    int      stall;
    result_t got;
    result_t want;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = recv_no_idle ? 0 : $urandom_range(0, GAP_MAX);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall = LONG_HOLD_CYCLES;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got.status   = status_t'(status);
      got.value    = value;
      got.position = position;
      got.count    = count;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, value", '0, got.value);
      end else begin
        want = pending_results.pop_front();
        if (got.status != want.status)
          report_mismatch("status", 32'(want.status), 32'(got.status));
        if (got.value != want.value)
          report_mismatch("value", want.value, got.value);
        if (got.position != want.position)
          report_mismatch("position", 32'(want.position), 32'(got.position));
        if (got.count != want.count)
          report_mismatch("count", 32'(want.count), 32'(got.count));
      end
    end
  end

  // Ends the run if the block stops moving transactions.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    result_t          none;
    stim_row_t        row;
    op_t              o;
    logic [KEY_W-1:0] k;
    logic [INDEX_W-1:0] ix;
    int               kind;
    int               draw;
    int               ins_pct;
    int               rem_pct;
    int               find_pct;

    none           = '0;
    mismatch_count = 0;
    table_count    = 0;
    order_signed   = 1'b0;
    send_no_idle   = 1'b0;
    recv_no_idle   = 1'b0;
    long_hold_req  = 1'b0;
    rst            <= 1'b1;
    in_valid       <= 1'b0;
    op             <= OP_INSERT;
    key            <= '0;
    index          <= '0;
    out_ready      <= 1'b0;
    cfg_valid      <= 1'b0;
    compare_signed <= 1'b0;

    // Empty table errors, extremes of the key, equal keys going in front.
    add_row(OP_READ,   32'h0,         6'd0,  1, STATUS_RANGE,   32'h0,         6'd0, 7'd0);
    add_row(OP_REMOVE, 32'h0,         6'd0,  1, STATUS_RANGE,   32'h0,         6'd0, 7'd0);
    add_row(OP_FIND,   32'h0,         6'd0,  1, STATUS_MISSING, 32'h0,         6'd0, 7'd0);
    add_row(OP_READ,   32'hFFFF_FFFF, 6'd63, 1, STATUS_RANGE,   32'h0,         6'd0, 7'd0);
    add_row(OP_INSERT, 32'hFFFF_FFFF, 6'd63, 1, STATUS_OK,      32'h0,         6'd0, 7'd1);
    add_row(OP_INSERT, 32'h0,         6'd0,  1, STATUS_OK,      32'h0,         6'd0, 7'd2);
    add_row(OP_INSERT, 32'h0,         6'd0,  1, STATUS_OK,      32'h0,         6'd0, 7'd3);
    add_row(OP_INSERT, 32'h8000_0000, 6'd0,  1, STATUS_OK,      32'h0,         6'd2, 7'd4);
    add_row(OP_READ,   32'h0,         6'd3,  1, STATUS_OK,      32'hFFFF_FFFF, 6'd3, 7'd4);
    add_row(OP_FIND,   32'hFFFF_FFFF, 6'd0,  1, STATUS_OK,      32'hFFFF_FFFF, 6'd3, 7'd4);
    add_row(OP_FIND,   32'h0,         6'd63, 1, STATUS_OK,      32'h0,         6'd0, 7'd4);
    add_row(OP_FIND,   32'h7FFF_FFFF, 6'd0,  1, STATUS_MISSING, 32'h0,         6'd0, 7'd4);
    add_row(OP_READ,   32'h0,         6'd4,  1, STATUS_RANGE,   32'h0,         6'd0, 7'd4);
    add_row(OP_REMOVE, 32'h0,         6'd4,  1, STATUS_RANGE,   32'h0,         6'd0, 7'd4);
    add_row(OP_REMOVE, 32'h0,         6'd3,  1, STATUS_OK,      32'h0,         6'd0, 7'd3);
    add_row(OP_REMOVE, 32'hFFFF_FFFF, 6'd0,  1, STATUS_OK,      32'h0,         6'd0, 7'd2);
    add_row(OP_INSERT, 32'h7FFF_FFFF, 6'd0,  0, STATUS_OK,      32'h0,         6'd0, 7'd0);
    add_row(OP_READ,   32'h0,         6'd2,  0, STATUS_OK,      32'h0,         6'd0, 7'd0);
    add_row(OP_INSERT, 32'hAAAA_5555, 6'd0,  0, STATUS_OK,      32'h0,         6'd0, 7'd0);
    add_row(OP_FIND,   32'hAAAA_5555, 6'd0,  0, STATUS_OK,      32'h0,         6'd0, 7'd0);
    add_row(OP_READ,   32'h0,         6'd1,  0, STATUS_OK,      32'h0,         6'd0, 7'd0);
    add_row(OP_REMOVE, 32'h0,         6'd1,  0, STATUS_OK,      32'h0,         6'd0, 7'd0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    write_compare_mode(1'b0);

    foreach (directed_rows[n]) begin
      row = directed_rows[n];
      send_item(row.op, row.key, row.index, row.typed, row.want);
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      in_valid <= 1'b0;
      wait_drained();
      write_compare_mode(phase == 0 ? 1'b1 : (phase == 1 ? 1'b0 : 1'($urandom_range(0, 1))));
      send_no_idle = ($urandom_range(0, 3) == 0);
      recv_no_idle = ($urandom_range(0, 3) == 0);
      // The long hold lets the sender run into a full pipeline.
      if (phase == HOLD_PHASE) long_hold_req = 1'b1;
      kind = phase % 3;
      case (kind)
        0:       begin ins_pct = 70; rem_pct = 10; find_pct = 10; end
        1:       begin ins_pct = 30; rem_pct = 25; find_pct = 25; end
        default: begin ins_pct = 15; rem_pct = 55; find_pct = 15; end
      endcase
      for (int item = 0; item < PHASE_ITEMS; item++) begin
        draw = $urandom_range(0, 99);
        if (draw < 10) begin
          o  = op_t'($urandom_range(0, 3));
          k  = $urandom;
          ix = INDEX_W'($urandom_range(0, 63));
        end else begin
          draw = $urandom_range(0, 99);
          if (draw < ins_pct) o = OP_INSERT;
          else if (draw < ins_pct + rem_pct) o = OP_REMOVE;
          else if (draw < ins_pct + rem_pct + find_pct) o = OP_FIND;
          else o = OP_READ;
          k  = (o == OP_INSERT || o == OP_FIND) ? pick_key() : $urandom;
          ix = pick_index();
        end
        send_item(o, k, ix, 1'b0, none);
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
